[rtl/core/scp_pkg.sv]
package scp_pkg;

    localparam int NUM_PAT = 7;
    localparam int PAT_CHARS = 10;
    localparam logic [3:0] LEN_SATURATE = 4'd11;

    localparam logic [2:0] MODE_INIT = 3'd0;
    localparam logic [2:0] MODE_HELO = 3'd1;
    localparam logic [2:0] MODE_MAIL = 3'd2;
    localparam logic [2:0] MODE_RCPT = 3'd3;
    localparam logic [2:0] MODE_DATA = 3'd4;
    localparam logic [2:0] MODE_QUIT = 3'd5;

    localparam logic [2:0] REPLY_GREETING = 3'd0;
    localparam logic [2:0] REPLY_HELLO    = 3'd1;
    localparam logic [2:0] REPLY_OK       = 3'd2;
    localparam logic [2:0] REPLY_START    = 3'd3;
    localparam logic [2:0] REPLY_QUEUED   = 3'd4;
    localparam logic [2:0] REPLY_BYE      = 3'd5;
    localparam logic [2:0] REPLY_SYNTAX   = 3'd6;

    localparam logic [1:0] CLASS_COMMAND   = 2'd0;
    localparam logic [1:0] CLASS_SENDER    = 2'd1;
    localparam logic [1:0] CLASS_RECIPIENT = 2'd2;
    localparam logic [1:0] CLASS_BODY      = 2'd3;

    localparam int PAT_HELO = 0;
    localparam int PAT_EHLO = 1;
    localparam int PAT_MAIL = 2;
    localparam int PAT_RCPT = 3;
    localparam int PAT_DATA = 4;
    localparam int PAT_RSET = 5;
    localparam int PAT_QUIT = 6;

    localparam logic [7:0] CHAR_CR  = 8'd13;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_DOT = 8'd46;

    localparam logic [NUM_PAT-1:0] ALL_CANDIDATES = '1;

    localparam logic [8*PAT_CHARS-1:0] PAT_STR [NUM_PAT] = '{
        "HELO      ",
        "EHLO      ",
        "MAIL FROM:",
        "RCPT TO:  ",
        "DATA      ",
        "RSET      ",
        "QUIT      "
    };
    localparam logic [3:0] PAT_LEN [NUM_PAT] = '{
        4'd4, 4'd4, 4'd10, 4'd8, 4'd4, 4'd4, 4'd4
    };

    typedef struct packed {
        logic [NUM_PAT-1:0] cand;
        logic [3:0]         len;
    } line_t;

    typedef struct packed {
        logic       reply_valid;
        logic [2:0] reply_code;
        logic       close_connection;
        logic [1:0] byte_class;
    } result_t;

    function automatic logic [7:0] pat_byte(input int idx, input logic [3:0] pos);
        logic [8*PAT_CHARS-1:0] sh;
        sh = PAT_STR[idx] << {pos, 3'b000};
        return sh[8*PAT_CHARS-1 -: 8];
    endfunction

    function automatic line_t feed_char(input line_t cur, input logic [7:0] c);
        line_t      nxt;
        logic [7:0] u;
        nxt = cur;
        u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        for (int i = 0; i < NUM_PAT; i++) begin
            if (cur.len < PAT_LEN[i] && pat_byte(i, cur.len) != u) begin
                nxt.cand[i] = 1'b0;
            end
        end
        if (cur.len < LEN_SATURATE) begin
            nxt.len = cur.len + 4'd1;
        end
        return nxt;
    endfunction

    function automatic logic has_pat(input line_t cur, input int idx, input logic exact);
        if (!cur.cand[idx]) begin
            return 1'b0;
        end
        return exact ? (cur.len == PAT_LEN[idx]) : (cur.len >= PAT_LEN[idx]);
    endfunction

    function automatic logic [7:0] term_byte(input logic [2:0] pos);
        logic [7:0] b;
        case (pos)
            3'd0:    b = CHAR_CR;
            3'd1:    b = CHAR_LF;
            3'd2:    b = CHAR_DOT;
            3'd3:    b = CHAR_CR;
            3'd4:    b = CHAR_LF;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

[rtl/core/scp_session.sv]
module scp_session (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic             cmd,
    input  logic [7:0]       data_byte,
    output scp_pkg::result_t res
);
    import scp_pkg::*;

    logic [2:0] mode_reg, mode_next;
    line_t      line_reg, line_next;
    logic       cr_seen_reg, cr_seen_next;
    logic [2:0] term_reg, term_next;

    always_comb begin
        line_t      st;
        logic [2:0] tp;
        mode_next    = mode_reg;
        line_next    = line_reg;
        cr_seen_next = cr_seen_reg;
        term_next    = term_reg;
        res          = '0;
        st           = line_reg;
        tp           = 3'd0;
        if (cmd) begin
            mode_next        = MODE_INIT;
            term_next        = 3'd0;
            line_next.len    = 4'd0;
            line_next.cand   = ALL_CANDIDATES;
            cr_seen_next     = 1'b0;
            res.reply_valid  = 1'b1;
            res.reply_code   = REPLY_GREETING;
        end else if (mode_reg == MODE_DATA) begin
            res.byte_class = CLASS_BODY;
            if (term_reg < 3'd5 && data_byte == term_byte(term_reg)) begin
                tp = term_reg + 3'd1;
            end else begin
                tp = (data_byte == CHAR_CR) ? 3'd1 : 3'd0;
            end
            term_next = tp;
            if (tp >= 3'd5) begin
                res.reply_valid = 1'b1;
                res.reply_code  = REPLY_QUEUED;
                mode_next       = MODE_HELO;
                term_next       = 3'd0;
                line_next.len   = 4'd0;
                line_next.cand  = ALL_CANDIDATES;
                cr_seen_next    = 1'b0;
            end
        end else if (cr_seen_reg && data_byte == CHAR_LF) begin
            res.reply_valid = 1'b1;
            if (has_pat(line_reg, PAT_HELO, 1'b0) || has_pat(line_reg, PAT_EHLO, 1'b0)) begin
                mode_next      = MODE_HELO;
                res.reply_code = REPLY_HELLO;
            end else if (has_pat(line_reg, PAT_MAIL, 1'b0)) begin
                mode_next      = MODE_MAIL;
                res.reply_code = REPLY_OK;
            end else if (has_pat(line_reg, PAT_RCPT, 1'b0)) begin
                mode_next      = MODE_RCPT;
                res.reply_code = REPLY_OK;
            end else if (has_pat(line_reg, PAT_DATA, 1'b1)) begin
                mode_next      = MODE_DATA;
                res.reply_code = REPLY_START;
                term_next      = 3'd2;
            end else if (has_pat(line_reg, PAT_RSET, 1'b1)) begin
                mode_next      = MODE_HELO;
                res.reply_code = REPLY_OK;
            end else if (has_pat(line_reg, PAT_QUIT, 1'b1)) begin
                mode_next            = MODE_QUIT;
                res.reply_code       = REPLY_BYE;
                res.close_connection = 1'b1;
            end else begin
                res.reply_code = REPLY_SYNTAX;
            end
            line_next.len  = 4'd0;
            line_next.cand = ALL_CANDIDATES;
            cr_seen_next   = 1'b0;
        end else begin
            // a pending lone cr becomes an ordinary line byte first
            if (cr_seen_reg) begin
                st = feed_char(st, CHAR_CR);
            end
            cr_seen_next = 1'b0;
            if (data_byte == CHAR_CR) begin
                cr_seen_next = 1'b1;
            end else begin
                if (st.cand[PAT_MAIL] && st.len >= PAT_LEN[PAT_MAIL]) begin
                    res.byte_class = CLASS_SENDER;
                end else if (st.cand[PAT_RCPT] && st.len >= PAT_LEN[PAT_RCPT]) begin
                    res.byte_class = CLASS_RECIPIENT;
                end
                st = feed_char(st, data_byte);
            end
            line_next = st;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_INIT;
            line_reg.len  <= 4'd0;
            line_reg.cand <= ALL_CANDIDATES;
            cr_seen_reg   <= 1'b0;
            term_reg      <= 3'd0;
        end else if (advance) begin
            mode_reg    <= mode_next;
            line_reg    <= line_next;
            cr_seen_reg <= cr_seen_next;
            term_reg    <= term_next;
        end
    end

endmodule

[rtl/core/scp_result_stage.sv]
module scp_result_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  scp_pkg::result_t res,
    output logic             can_load,
    output logic             m_valid,
    input  logic             m_ready,
    output scp_pkg::result_t m_res
);
    import scp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && can_load) begin
            res_reg <= res;
        end
    end

endmodule

[rtl/core/smtp_command_stream_parser.sv]
// an accepted input transfer is held in the input register, then its result in the result register, before the m_ side
// throughput: one item per cycle while m_ready lets the result register drain; the session state updates per item
// an input register and a result register part the channels; s_ready still follows m_ready through can_load
// reset: synchronous active-low aresetn empties both registers and returns the
// session to the initial mode with a cleared line and terminator matcher
module smtp_command_stream_parser (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_reply_valid,
    output logic [2:0] m_reply_code,
    output logic       m_close_connection,
    output logic [1:0] m_byte_class
);
    import scp_pkg::*;

    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;
    logic       can_load;
    logic       advance;
    result_t    res;
    result_t    m_res;

    assign advance = in_valid_reg && can_load;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg  <= s_cmd;
            in_byte_reg <= s_data_byte;
        end
    end

    scp_session u_session (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .cmd       (in_cmd_reg),
        .data_byte (in_byte_reg),
        .res       (res)
    );

    scp_result_stage u_result (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (in_valid_reg),
        .res      (res),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_reply_valid      = m_res.reply_valid;
    assign m_reply_code       = m_res.reply_code;
    assign m_close_connection = m_res.close_connection;
    assign m_byte_class       = m_res.byte_class;

endmodule

[bench/smtp_command_stream_parser_tb.sv]
module smtp_command_stream_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scp_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1150;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [39:0] END_OF_DATA = {CHAR_CR, CHAR_LF, CHAR_DOT, CHAR_CR, CHAR_LF};

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_cmd = 1'b0;
    logic [7:0] s_data_byte = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_reply_valid;
    logic [2:0] m_reply_code;
    logic       m_close_connection;
    logic [1:0] m_byte_class;

    // session state of the predictor
    logic [2:0]         sess_mode;
    logic [3:0]         line_len;
    logic [NUM_PAT-1:0] cand;
    logic               cr_pending;
    logic [2:0]         term_pos;

    result_t expected_replies[$];
    int      items_sent = 0;
    int      mismatches = 0;
    int      idle_cycles = 0;
    int      tx_run = 0;
    bit      tx_burst = 1'b0;
    int      rx_run = 0;
    bit      rx_burst = 1'b0;

    smtp_command_stream_parser dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cmd              (s_cmd),
        .s_data_byte        (s_data_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_reply_valid      (m_reply_valid),
        .m_reply_code       (m_reply_code),
        .m_close_connection (m_close_connection),
        .m_byte_class       (m_byte_class)
    );

    always #10 aclk = ~aclk;

    function automatic int pattern_len(input int p);
        case (p)
            PAT_MAIL: return 10;
            PAT_RCPT: return 8;
            default:  return 4;
        endcase
    endfunction

    function automatic logic [7:0] pattern_char(input int p, input int pos);
        logic [79:0] txt;
        case (p)
            PAT_HELO: txt = "HELO";
            PAT_EHLO: txt = "EHLO";
            PAT_MAIL: txt = "MAIL FROM:";
            PAT_RCPT: txt = "RCPT TO:";
            PAT_DATA: txt = "DATA";
            PAT_RSET: txt = "RSET";
            default:  txt = "QUIT";
        endcase
        return txt[8*(pattern_len(p)-1-pos) +: 8];
    endfunction

    function automatic void clear_line();
        line_len = 4'd0;
        cand = ALL_CANDIDATES;
        cr_pending = 1'b0;
    endfunction

    function automatic void restart_session();
        sess_mode = MODE_INIT;
        term_pos = 3'd0;
        clear_line();
    endfunction

    function automatic void take_char(input logic [7:0] c);
        logic [7:0] up;
        up = (c >= 8'd97 && c <= 8'd122) ? c - 8'd32 : c;
        for (int p = 0; p < NUM_PAT; p++) begin
            if (line_len < pattern_len(p) && pattern_char(p, line_len) != up) begin
                cand[p] = 1'b0;
            end
        end
        if (line_len < LEN_SATURATE) begin
            line_len = line_len + 4'd1;
        end
    endfunction

    function automatic logic matched(input int p, input logic exact);
        if (!cand[p]) begin
            return 1'b0;
        end
        return exact ? (line_len == pattern_len(p)) : (line_len >= pattern_len(p));
    endfunction

    function automatic result_t predict_reply(input logic cmd, input logic [7:0] b);
        result_t r;
        r = '0;
        if (cmd) begin
            restart_session();
            r.reply_valid = 1'b1;
            r.reply_code = REPLY_GREETING;
        end else if (sess_mode == MODE_DATA) begin
            r.byte_class = CLASS_BODY;
            if (term_pos < 3'd5 && b == END_OF_DATA[8*(4-int'(term_pos)) +: 8]) begin
                term_pos = term_pos + 3'd1;
            end else begin
                term_pos = (b == CHAR_CR) ? 3'd1 : 3'd0;
            end
            if (term_pos >= 3'd5) begin
                r.reply_valid = 1'b1;
                r.reply_code = REPLY_QUEUED;
                sess_mode = MODE_HELO;
                term_pos = 3'd0;
                clear_line();
            end
        end else if (cr_pending && b == CHAR_LF) begin
            r.reply_valid = 1'b1;
            if (matched(PAT_HELO, 1'b0) || matched(PAT_EHLO, 1'b0)) begin
                sess_mode = MODE_HELO;
                r.reply_code = REPLY_HELLO;
            end else if (matched(PAT_MAIL, 1'b0)) begin
                sess_mode = MODE_MAIL;
                r.reply_code = REPLY_OK;
            end else if (matched(PAT_RCPT, 1'b0)) begin
                sess_mode = MODE_RCPT;
                r.reply_code = REPLY_OK;
            end else if (matched(PAT_DATA, 1'b1)) begin
                sess_mode = MODE_DATA;
                r.reply_code = REPLY_START;
                term_pos = 3'd2;
            end else if (matched(PAT_RSET, 1'b1)) begin
                sess_mode = MODE_HELO;
                r.reply_code = REPLY_OK;
            end else if (matched(PAT_QUIT, 1'b1)) begin
                sess_mode = MODE_QUIT;
                r.reply_code = REPLY_BYE;
                r.close_connection = 1'b1;
            end else begin
                r.reply_code = REPLY_SYNTAX;
            end
            clear_line();
        end else begin
            // a carriage return without its line feed joins the line
            if (cr_pending) begin
                take_char(CHAR_CR);
                cr_pending = 1'b0;
            end
            if (b == CHAR_CR) begin
                cr_pending = 1'b1;
            end else begin
                if (cand[PAT_MAIL] && line_len >= pattern_len(PAT_MAIL)) begin
                    r.byte_class = CLASS_SENDER;
                end else if (cand[PAT_RCPT] && line_len >= pattern_len(PAT_RCPT)) begin
                    r.byte_class = CLASS_RECIPIENT;
                end
                take_char(b);
            end
        end
        return r;
    endfunction

    task automatic send_item(input logic cmd, input logic [7:0] b);
        int      gap;
        result_t want;
        if (tx_run == 0) begin
            tx_run = $urandom_range(1, 40);
            tx_burst = ($urandom_range(0, 3) == 0);
        end
        tx_run--;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = predict_reply(cmd, b);
        expected_replies.push_back(want);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(1'b0, b);
    endtask

    task automatic send_connect();
        send_item(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_word(input string s, input bit mix_case);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mix_case && c >= 8'd65 && c <= 8'd90 && $urandom_range(0, 1) == 1) begin
                c = c + 8'd32;
            end
            send_byte(c);
        end
    endtask

    task automatic send_crlf();
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    task automatic end_line();
        case ($urandom_range(0, 19))
            0: begin
                send_byte(CHAR_LF);
                send_crlf();
            end
            1: begin
                send_byte(CHAR_CR);
                send_byte(8'($urandom_range(32, 126)));
                send_crlf();
            end
            default: send_crlf();
        endcase
    endtask

    task automatic send_arg(input int n);
        repeat (n) send_byte(8'($urandom_range(32, 126)));
    endtask

    task automatic send_body();
        int n;
        if ($urandom_range(0, 3) == 0) begin
            // data line's own CR LF opens the terminator
            send_byte(CHAR_DOT);
            send_crlf();
        end else begin
            n = $urandom_range(0, 24);
            repeat (n) begin
                case ($urandom_range(0, 7))
                    0: send_byte(CHAR_CR);
                    1: send_byte(CHAR_LF);
                    2: send_byte(CHAR_DOT);
                    3: begin
                        if ($urandom_range(0, 19) == 0) begin
                            send_connect();
                        end else begin
                            send_byte(8'($urandom_range(0, 255)));
                        end
                    end
                    default: send_byte(8'($urandom_range(0, 255)));
                endcase
            end
            send_crlf();
            send_byte(CHAR_DOT);
            send_crlf();
        end
    endtask

    task automatic test_connect_events();
        send_item(1'b1, 8'hFF);
        send_item(1'b1, 8'h00);
    endtask

    task automatic test_line_edge_cases();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHAR_CR);
        send_byte("x");
        send_byte(CHAR_LF);
        send_crlf();
        send_crlf();
        send_word("quit", 1'b0);
        send_crlf();
        send_word("rset", 1'b0);
        send_crlf();
    endtask

    task automatic test_random_sessions();
        int stop_at;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 15))
                0: send_connect();
                1, 2: begin
                    send_word(($urandom_range(0, 1) == 1) ? "HELO" : "EHLO", 1'b1);
                    if ($urandom_range(0, 1) == 1) begin
                        send_byte(" ");
                        send_arg($urandom_range(0, 20));
                    end
                    end_line();
                end
                3, 4: begin
                    send_word("MAIL FROM:", 1'b1);
                    send_arg($urandom_range(0, 25));
                    end_line();
                end
                5, 6: begin
                    send_word("RCPT TO:", 1'b1);
                    send_arg($urandom_range(0, 25));
                    end_line();
                end
                7, 8: begin
                    send_word("DATA", 1'b1);
                    send_crlf();
                    send_body();
                end
                9: begin
                    send_word("RSET", 1'b1);
                    end_line();
                end
                10: begin
                    send_word("QUIT", 1'b1);
                    end_line();
                end
                11: begin
                    case ($urandom_range(0, 2))
                        0: send_word("DATA", 1'b1);
                        1: send_word("RSET", 1'b1);
                        default: send_word("QUIT", 1'b1);
                    endcase
                    send_arg($urandom_range(1, 12));
                    end_line();
                end
                12: begin
                    case ($urandom_range(0, 3))
                        0: send_word("MAIL FROM", 1'b1);
                        1: send_word("RCPT TO", 1'b1);
                        2: send_word("HEL", 1'b1);
                        default: send_word("MAIL TO:", 1'b1);
                    endcase
                    send_arg($urandom_range(0, 6));
                    end_line();
                end
                13: begin
                    repeat ($urandom_range(0, 30)) send_byte(8'($urandom_range(0, 255)));
                    send_crlf();
                end
                14: begin
                    if ($urandom_range(0, 1) == 1) begin
                        send_crlf();
                    end else begin
                        send_word("QUI", 1'b1);
                        send_byte(CHAR_CR);
                        send_byte("T");
                        send_crlf();
                    end
                end
                default: begin
                    repeat ($urandom_range(12, 30)) send_byte(8'($urandom_range(65, 122)));
                    send_crlf();
                end
            endcase
        end
    endtask

    // result side: draws a stall before each transfer, none inside a burst
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (rx_run == 0) begin
                rx_run = $urandom_range(1, 40);
                rx_burst = ($urandom_range(0, 3) == 0);
            end
            rx_run--;
            stall = rx_burst ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected reply: valid=%0d code=%0d close=%0d class=%0d",
                             m_reply_valid, m_reply_code, m_close_connection, m_byte_class);
                end
            end else begin
                want = expected_replies.pop_front();
                if (m_reply_valid !== want.reply_valid || m_reply_code !== want.reply_code ||
                    m_close_connection !== want.close_connection ||
                    m_byte_class !== want.byte_class) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("reply differs: expected valid=%0d code=%0d close=%0d class=%0d",
                                 want.reply_valid, want.reply_code, want.close_connection,
                                 want.byte_class);
                        $display("               got      valid=%0d code=%0d close=%0d class=%0d",
                                 m_reply_valid, m_reply_code, m_close_connection,
                                 m_byte_class);
                    end
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("smtp_command_stream_parser: mismatch");
            $finish;
        end
    end

    initial begin
        restart_session();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_connect_events();
        test_line_edge_cases();
        test_random_sessions();
        s_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_replies.size() == 0) begin
            $display("smtp_command_stream_parser: match");
        end else begin
            $display("smtp_command_stream_parser: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/scp_pkg.sv
rtl/core/scp_session.sv
rtl/core/scp_result_stage.sv
rtl/core/smtp_command_stream_parser.sv
bench/smtp_command_stream_parser_tb.sv
